/* sv/anchor_spring_damper_macros.svh */
// Assertion macros for the anchor spring block.
`ifndef ANCHOR_SPRING_DAMPER_MACROS_SVH
`define ANCHOR_SPRING_DAMPER_MACROS_SVH
`ifndef SYNTH
// checked outside reset
`define ASD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define ASD_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASD_ASSERT(lbl, prop, msg)
`define ASD_ASSERT_ANY(lbl, prop, msg)
`endif
`endif

/* sv/asd_pkg.sv */
package asd_pkg;

  localparam int ANCHORS = 16;
  localparam int IDX_W = (ANCHORS > 1) ? $clog2(ANCHORS) : 1;
  localparam logic [15:0] TIME_STEP_RST = 16'd1092;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS = 64;
  localparam int CNT_W = 6;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_MUL, S_ACC, S_OFS, S_SQRT, S_DIV, S_FIN, S_DONE
  } state_t;

  // multiplier jobs, in issue order
  typedef enum logic [3:0] {
    OP_KX, OP_DX, OP_KY, OP_DY, OP_AX, OP_AY, OP_VX, OP_VY,
    OP_SQX, OP_SQY, OP_MO2, OP_NX, OP_NY
  } op_t;

  // saturate a 34-bit signed value to Q16.16
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      sat34 = v[31:0];
    end else if (v[33]) begin
      sat34 = 32'sh8000_0000;
    end else begin
      sat34 = 32'sh7FFF_FFFF;
    end
  endfunction

  // round magnitude product to Q16.16, ties away from zero, apply sign, saturate
  function automatic logic signed [31:0] qround(input logic [63:0] p, input logic neg);
    logic [63:0] s;
    logic [47:0] r;
    s = p + 64'h8000;
    r = s[63:16];
    if (neg) begin
      if (r >= 48'h8000_0000) begin
        qround = 32'sh8000_0000;
      end else begin
        qround = $signed(~r[31:0] + 32'd1);
      end
    end else begin
      if (r > 48'h7FFF_FFFF) begin
        qround = 32'sh7FFF_FFFF;
      end else begin
        qround = $signed(r[31:0]);
      end
    end
  endfunction

  // halve with truncation toward zero
  function automatic logic signed [31:0] halve(input logic signed [31:0] v);
    logic [32:0] m;
    logic [32:0] h;
    m = v[31] ? (33'd0 - 33'(v)) : 33'(v);
    h = m >> 1;
    halve = v[31] ? $signed(32'(33'd0 - h)) : $signed(h[31:0]);
  endfunction

endpackage

/* sv/anchor_spring_damper.sv */
// One word at a time: in_ready is high only while idle, so a new word is taken
// only after the previous result has been loaded into the output register; an
// output stall holds the block in its done state. The work is done by the
// shared 33x32 multiplier, the 32-step square root and two 64-step restoring
// divisions.
// Reset (rst, synchronous): anchors uninitialized, no result held, time_step 1092.
`include "anchor_spring_damper_macros.svh"

module anchor_spring_damper (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               restart,
  input  logic [3:0]         anchor_index,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic [30:0]        stiffness,
  input  logic [30:0]        damping,
  input  logic [30:0]        max_offset,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic               clamped
);
  import asd_pkg::*;

  state_t state, state_next;
  op_t    op, op_next;

  logic [15:0] time_step;

  // latched input word
  logic [IDX_W-1:0]   idx;
  logic signed [31:0] tx, ty;
  logic [30:0]        k, d, mo;

  // per-anchor state; position/velocity stores need no reset
  logic [ANCHORS-1:0] rdy;
  logic signed [31:0] mem_px [ANCHORS];
  logic signed [31:0] mem_py [ANCHORS];
  logic signed [31:0] mem_vx [ANCHORS];
  logic signed [31:0] mem_vy [ANCHORS];

  // working registers
  logic signed [31:0] px, py, vx, vy, ax, ay, t1;
  logic [63:0]        prod;
  logic               prod_neg;
  logic [63:0]        sq;
  logic               ox_neg, oy_neg, halved;
  logic [31:0]        mx, my;
  logic [63:0]        sv, res, bitm;
  logic [63:0]        dvd;
  logic [31:0]        rem, quo, qx;
  logic               div_y;
  logic [CNT_W-1:0]   cnt;
  logic               cl;

  logic               accept;
  logic [IDX_W-1:0]   idx_in;

  // shared multiplier operands
  logic signed [33:0] opa;
  logic signed [32:0] opb;
  logic [32:0]        ma;
  logic [31:0]        mb;
  logic [63:0]        mul_res;
  logic signed [31:0] rnd;

  // clamp offset
  logic signed [32:0] ox, oy;
  logic [32:0]        omx, omy;

  // square root step
  logic [63:0]        trial;
  // divider step
  logic [32:0]        dsh;
  logic               qbit;
  logic [31:0]        quo_new;
  logic [31:0]        len;

  logic               out_free;

  assign accept   = in_valid && in_ready;
  assign idx_in   = (32'(anchor_index) >= ANCHORS) ? IDX_W'(ANCHORS - 1) : IDX_W'(anchor_index);
  assign len      = res[31:0];
  assign out_free = !out_valid || out_ready;

  always_comb begin
    opa = '0;
    opb = '0;
    case (op)
      OP_KX:   begin opa = 34'(tx) - 34'(px); opb = $signed({2'b0, k}); end
      OP_DX:   begin opa = 34'(vx); opb = $signed({2'b0, d}); end
      OP_KY:   begin opa = 34'(ty) - 34'(py); opb = $signed({2'b0, k}); end
      OP_DY:   begin opa = 34'(vy); opb = $signed({2'b0, d}); end
      OP_AX:   begin opa = 34'(ax); opb = $signed({17'b0, time_step}); end
      OP_AY:   begin opa = 34'(ay); opb = $signed({17'b0, time_step}); end
      OP_VX:   begin opa = 34'(vx); opb = $signed({17'b0, time_step}); end
      OP_VY:   begin opa = 34'(vy); opb = $signed({17'b0, time_step}); end
      OP_SQX:  begin opa = $signed({2'b0, mx}); opb = $signed({1'b0, mx}); end
      OP_SQY:  begin opa = $signed({2'b0, my}); opb = $signed({1'b0, my}); end
      OP_MO2:  begin opa = $signed({3'b0, mo}); opb = $signed({2'b0, mo}); end
      OP_NX:   begin opa = $signed({2'b0, mx}); opb = $signed({2'b0, mo}); end
      OP_NY:   begin opa = $signed({2'b0, my}); opb = $signed({2'b0, mo}); end
      default: begin opa = '0; opb = '0; end
    endcase
    ma = opa[33] ? 33'(-opa) : 33'(opa);
    mb = opb[32] ? 32'(-opb) : 32'(opb);
    mul_res = {31'b0, ma} * {32'b0, mb};
  end

  assign rnd = qround(prod, prod_neg);

  assign ox  = 33'(px) - 33'(tx);
  assign oy  = 33'(py) - 33'(ty);
  assign omx = ox[32] ? 33'(-ox) : 33'(ox);
  assign omy = oy[32] ? 33'(-oy) : 33'(oy);

  assign trial   = res + bitm;
  assign dsh     = {rem, dvd[63]};
  assign qbit    = dsh >= {1'b0, len};
  assign quo_new = {quo[30:0], qbit};

  // sequencer: next state and handshake
  always_comb begin
    state_next = state;
    op_next    = op;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_LOAD;
          op_next    = OP_KX;
        end
      end
      S_LOAD: state_next = S_MUL;
      S_MUL:  state_next = S_ACC;
      S_ACC: begin
        state_next = S_MUL;
        case (op)
          OP_KX: op_next = OP_DX;
          OP_DX: op_next = OP_KY;
          OP_KY: op_next = OP_DY;
          OP_DY: op_next = OP_AX;
          OP_AX: op_next = OP_AY;
          OP_AY: op_next = OP_VX;
          OP_VX: op_next = OP_VY;
          OP_VY: begin
            op_next    = OP_SQX;
            state_next = (mo != '0) ? S_OFS : S_DONE;
          end
          OP_SQX: op_next = OP_SQY;
          OP_SQY: begin
            op_next = halved ? OP_NX : OP_MO2;
            if (halved) begin
              state_next = S_SQRT;
            end
          end
          OP_MO2: begin
            op_next    = OP_NX;
            state_next = (sq > prod) ? S_SQRT : S_DONE;
          end
          OP_NX:   state_next = S_DIV;
          OP_NY:   state_next = S_DIV;
          default: state_next = S_IDLE;
        endcase
      end
      S_OFS: state_next = S_MUL;
      S_SQRT: begin
        if (cnt == CNT_W'(SQRT_STEPS - 1)) begin
          state_next = S_MUL;
        end
      end
      S_DIV: begin
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          if (div_y) begin
            state_next = S_FIN;
          end else begin
            state_next = S_MUL;
            op_next    = OP_NY;
          end
        end
      end
      S_FIN:  state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_KX;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= TIME_STEP_RST;
      rdy       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wen) begin
        time_step <= cfg_wdata;
      end
      if (accept && restart) begin
        rdy <= '0;
      end else if (state == S_DONE && out_free) begin
        rdy[idx] <= 1'b1;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // anchor stores
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      mem_px[idx] <= px;
      mem_py[idx] <= py;
      mem_vx[idx] <= vx;
      mem_vy[idx] <= vy;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          idx <= idx_in;
          tx  <= target_x;
          ty  <= target_y;
          k   <= stiffness;
          d   <= damping;
          mo  <= max_offset;
        end
      end
      S_LOAD: begin
        // uninitialized anchor starts at rest on its target
        px     <= rdy[idx] ? mem_px[idx] : tx;
        py     <= rdy[idx] ? mem_py[idx] : ty;
        vx     <= rdy[idx] ? mem_vx[idx] : '0;
        vy     <= rdy[idx] ? mem_vy[idx] : '0;
        cl     <= 1'b0;
        halved <= 1'b0;
        div_y  <= 1'b0;
      end
      S_MUL: begin
        prod     <= mul_res;
        prod_neg <= opa[33] ^ opb[32];
      end
      S_ACC: begin
        case (op)
          OP_KX: t1 <= rnd;
          OP_DX: ax <= sat34(34'(t1) - 34'(rnd));
          OP_KY: t1 <= rnd;
          OP_DY: ay <= sat34(34'(t1) - 34'(rnd));
          OP_AX: vx <= sat34(34'(vx) + 34'(rnd));
          OP_AY: vy <= sat34(34'(vy) + 34'(rnd));
          OP_VX: px <= sat34(34'(px) + 34'(rnd));
          OP_VY: py <= sat34(34'(py) + 34'(rnd));
          OP_SQX: sq <= prod;
          OP_SQY: begin
            sq   <= sq + prod;
            sv   <= sq + prod;
            res  <= '0;
            bitm <= 64'h4000_0000_0000_0000;
            cnt  <= '0;
          end
          OP_MO2: begin
            sv   <= sq;
            res  <= '0;
            bitm <= 64'h4000_0000_0000_0000;
            cnt  <= '0;
          end
          OP_NX, OP_NY: begin
            dvd <= prod + {33'b0, len[31:1]};
            rem <= '0;
            quo <= '0;
            cnt <= '0;
          end
          default: t1 <= t1;
        endcase
      end
      S_OFS: begin
        ox_neg <= ox[32];
        oy_neg <= oy[32];
        // offsets too long for 31 bits are halved and always clamped, with no length test
        if (omx[32] || omx[31] || omy[32] || omy[31]) begin
          mx     <= omx[32:1];
          my     <= omy[32:1];
          halved <= 1'b1;
        end else begin
          mx <= omx[31:0];
          my <= omy[31:0];
        end
      end
      S_SQRT: begin
        // one result bit per cycle
        if (sv >= trial) begin
          sv  <= sv - trial;
          res <= (res >> 1) + bitm;
        end else begin
          res <= res >> 1;
        end
        bitm <= bitm >> 2;
        cnt  <= cnt + 1'b1;
      end
      S_DIV: begin
        // restoring division, one quotient bit per cycle
        if (qbit) begin
          rem <= 32'(dsh - {1'b0, len});
        end else begin
          rem <= dsh[31:0];
        end
        dvd <= dvd << 1;
        quo <= quo_new;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1) && !div_y) begin
          qx    <= quo_new;
          div_y <= 1'b1;
        end
      end
      S_FIN: begin
        // pull back onto the max_offset circle; zero length falls back to target
        if (len == '0) begin
          px <= tx;
          py <= ty;
        end else begin
          px <= sat34(ox_neg ? (34'(tx) - $signed({2'b0, qx}))
                             : (34'(tx) + $signed({2'b0, qx})));
          py <= sat34(oy_neg ? (34'(ty) - $signed({2'b0, quo}))
                             : (34'(ty) + $signed({2'b0, quo})));
        end
        vx <= halve(vx);
        vy <= halve(vy);
        cl <= 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          pos_x   <= px;
          pos_y   <= py;
          clamped <= cl;
        end
      end
      default: cl <= cl;
    endcase
  end

  `ASD_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "accepted while busy")
  `ASD_ASSERT(a_out_from_done, $rose(out_valid) |-> $past(state) == S_DONE, "stray result")
  `ASD_ASSERT(a_div_nonzero, state == S_DIV |-> len != '0, "division by zero length")
  `ASD_ASSERT_ANY(a_reset_clear, rst |=> rdy == '0 && !out_valid, "reset did not clear")

endmodule

/* sim/anchor_spring_damper_test.sv */
module anchor_spring_damper_test;
  import asd_pkg::*;

  // one result word: position after the step plus the clamp flag
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               clamp;
  } anchor_pos_t;

  // Follows every anchor's spring and keeps the positions still owed by the block.
  class anchor_tracker;
    logic signed [31:0] px[ANCHORS];
    logic signed [31:0] py[ANCHORS];
    logic signed [31:0] vx[ANCHORS];
    logic signed [31:0] vy[ANCHORS];
    bit                 live[ANCHORS];
    logic [15:0]        dt;
    anchor_pos_t        owed[$];
    int                 errors;
    int                 words;
    int                 clamps;

    function new();
      dt = TIME_STEP_RST;
      foreach (live[i]) live[i] = 0;
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Q16.16 product, rounded half away from zero, saturated
    function longint qprod(longint a, longint b);
      bit neg;
      longint unsigned ma, mb, r;
      longint s;
      neg = (a < 0) != (b < 0);
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      r = (ma * mb + 64'h8000) >> 16;
      s = r > 64'h8000_0000 ? 64'h8000_0000 : r;
      return sat(neg ? -s : s);
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function longint half(longint v);
      longint unsigned m;
      m = (v < 0 ? -v : v) >> 1;
      return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function void note_word(bit rs, logic [3:0] a, logic signed [31:0] tx_in,
                            logic signed [31:0] ty_in, logic [30:0] k_in,
                            logic [30:0] d_in, logic [30:0] mo_in);
      longint tx, ty, k, d, mo, x, y, u, w, ax, ay, ox, oy, nx, ny;
      longint unsigned mx, my, len;
      bit over;
      anchor_pos_t e;
      tx = longint'(tx_in); ty = longint'(ty_in);
      k = longint'(k_in); d = longint'(d_in); mo = longint'(mo_in);
      e.clamp = 0;
      if (rs) foreach (live[i]) live[i] = 0;
      if (!live[a]) begin
        live[a] = 1;
        px[a] = tx_in; py[a] = ty_in; vx[a] = 0; vy[a] = 0;
      end
      x = longint'(px[a]); y = longint'(py[a]);
      u = longint'(vx[a]); w = longint'(vy[a]);
      ax = sat(qprod(tx - x, k) - qprod(u, d));
      ay = sat(qprod(ty - y, k) - qprod(w, d));
      u = sat(u + qprod(ax, longint'(dt)));
      w = sat(w + qprod(ay, longint'(dt)));
      x = sat(x + qprod(u, longint'(dt)));
      y = sat(y + qprod(w, longint'(dt)));
      if (mo > 0) begin
        ox = x - tx;
        oy = y - ty;
        mx = ox < 0 ? -ox : ox;
        my = oy < 0 ? -oy : oy;
        if (mx >= 64'h8000_0000 || my >= 64'h8000_0000) begin
          mx >>= 1;
          my >>= 1;
          over = 1;
        end else begin
          over = (mx * mx + my * my) > longint'(mo) * longint'(mo);
        end
        if (over) begin
          len = root(mx * mx + my * my);
          if (len == 0) begin
            x = tx; y = ty;
          end else begin
            nx = (mx * mo + len / 2) / len;
            ny = (my * mo + len / 2) / len;
            x = sat(tx + (ox < 0 ? -nx : nx));
            y = sat(ty + (oy < 0 ? -ny : ny));
          end
          u = half(u);
          w = half(w);
          e.clamp = 1;
        end
      end
      px[a] = 32'(x); py[a] = 32'(y); vx[a] = 32'(u); vy[a] = 32'(w);
      e.x = 32'(x); e.y = 32'(y);
      owed.insert(owed.size(), e);
      words++;
    endfunction

    function void check_result(logic signed [31:0] x, logic signed [31:0] y, logic c);
      anchor_pos_t e;
      if (owed.size() == 0) begin
        $error("result word with nothing expected: pos_x %0d pos_y %0d", x, y);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (x !== e.x) begin
        $error("pos_x expected %0d got %0d", e.x, x); errors++;
      end
      if (y !== e.y) begin
        $error("pos_y expected %0d got %0d", e.y, y); errors++;
      end
      if (c !== e.clamp) begin
        $error("clamped expected %0d got %0d", e.clamp, c); errors++;
      end
      if (e.clamp) clamps++;
    endfunction
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_wen = 0;
  logic [15:0]        cfg_wdata = '0;
  logic               in_valid = 0;
  logic               in_ready;
  logic               restart = 0;
  logic [3:0]         anchor_index = '0;
  logic signed [31:0] target_x = '0;
  logic signed [31:0] target_y = '0;
  logic [30:0]        stiffness = '0;
  logic [30:0]        damping = '0;
  logic [30:0]        max_offset = '0;
  logic               out_valid;
  logic               out_ready = 0;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic               clamped;

  anchor_tracker springs = new();
  bit  no_idle = 0;     // stretch where neither side idles
  bit  hold_go = 0;     // main asks for one long receiver hold-off
  bit  hold_done = 0;
  int  hold_left = 0;
  longint cycles = 0;

  anchor_spring_damper dut (.*);

  always #5 clk = ~clk;

  // watchdog: ends the run as a mismatch if the 815 words, stalls and gaps outlast it
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: check accepted words, random stalls, one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) springs.check_result(pos_x, pos_y, clamped);
      if (hold_go && !hold_done) begin
        hold_done = 1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 0;
      end else begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= 24);
      end
    end
  end

  // offer one word, hold it until taken, then maybe leave a gap
  task automatic send_word(bit rs, logic [3:0] a, logic signed [31:0] tx,
                           logic signed [31:0] ty, logic [30:0] k, logic [30:0] d,
                           logic [30:0] mo);
    in_valid <= 1;
    restart <= rs; anchor_index <= a; target_x <= tx; target_y <= ty;
    stiffness <= k; damping <= d; max_offset <= mo;
    do @(posedge clk); while (!in_ready);
    springs.note_word(rs, a, tx, ty, k, d, mo);
    if (!no_idle && $urandom_range(0, 99) < 24) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // sender pause: let every owed word come back
  task automatic drain();
    in_valid <= 0;
    while (springs.owed.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_step(logic [15:0] v);
    cfg_wen <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 0;
    springs.dt = v;
  endtask

  function automatic logic [30:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 31'h7FFF_FFFF;
      2: return 31'($urandom);
      default: return 31'($urandom_range(0, 40 << 16));
    endcase
  endfunction

  function automatic logic [30:0] pick_limit();
    case ($urandom_range(0, 5))
      0, 1: return '0;
      2: return 31'($urandom);
      3: return 31'd1;
      default: return 31'($urandom_range(1, 8 << 16));
    endcase
  endfunction

  // mostly a few anchors chasing targets that wander near a point, now and
  // then a jump or a full-range target so saturation and clamps show up
  task automatic random_words(int n);
    logic signed [31:0] bx, by, tx, ty;
    logic [3:0] a;
    bx = $urandom_range(0, 200 << 16) - (100 << 16);
    by = $urandom_range(0, 200 << 16) - (100 << 16);
    repeat (n) begin
      a = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0: begin tx = $urandom; ty = $urandom; end
        1: begin
          bx = $urandom_range(0, 200 << 16) - (100 << 16);
          by = $urandom_range(0, 200 << 16) - (100 << 16);
          tx = bx; ty = by;
        end
        default: begin
          tx = bx + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
          ty = by + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
        end
      endcase
      send_word($urandom_range(0, 19) == 0, a, tx, ty, pick_gain(), pick_gain(),
                pick_limit());
    end
  endtask

  initial begin
    logic [15:0] steps[5];
    steps = '{16'd0, 16'hFFFF, 16'd1092, 16'h8000, 16'h0000};
    steps[4] = 16'($urandom);
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, first step on an anchor, restart, clamp on/off
    send_word(0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0);
    send_word(0, 15, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 0, 31'h7FFF_FFFF);
    send_word(0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1);
    send_word(0, 15, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF, 0, 1);
    send_word(0, 3, 0, 0, 31'(10 << 16), 31'(1 << 16), 31'(1 << 16));
    send_word(0, 3, 50 << 16, -(50 << 16), 31'(10 << 16), 31'(1 << 16), 31'(1 << 16));
    send_word(0, 3, 50 << 16, -(50 << 16), 31'(10 << 16), 31'(1 << 16), 31'(1 << 16));
    send_word(0, 3, 50 << 16, -(50 << 16), 31'(10 << 16), 31'(1 << 16), 0);
    send_word(1, 3, 7 << 16, 7 << 16, 31'(10 << 16), 31'(1 << 16), 31'(1 << 16));
    send_word(0, 0, 0, 0, 0, 0, 0);
    send_word(0, 15, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_word(0, 5, 1, -1, 1, 1, 1);
    send_word(0, 5, -(1 << 30), 1 << 30, 31'h7FFF_FFFF, 5, 31'h7FFF_FFFF);
    send_word(1, 5, 32'sh5555_5555, 32'shAAAA_AAAA, 31'h2AAA_AAAA, 31'h5555_5555,
              31'h5555_5555);
    send_word(0, 10, 32'shAAAA_AAAA, 32'sh5555_5555, 31'h5555_5555, 31'h2AAA_AAAA,
              31'h2AAA_AAAA);

    for (int p = 0; p < 5; p++) begin
      drain();
      set_step(steps[p]);
      no_idle = (p == 3);
      if (p == 2) hold_go = 1;   // receiver sits out while words keep coming
      random_words(160);
    end
    no_idle = 0;

    drain();
    repeat (200) @(posedge clk);
    $display("covered %0d words, %0d clamped, five time steps incl. 0 and 65535",
             springs.words, springs.clamps);
    if (springs.errors == 0 && springs.owed.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
